>>> hdl/toiq_pkg.sv
// shared types and codes of the timestamp-ordered issue queue
`default_nettype none

package toiq_pkg;

	// operation codes carried in the input tuser
	localparam logic OP_INSERT  = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	// commands broadcast to every cell of the chain
	typedef struct packed {
		logic ins;
		logic pop;
	} cell_ctrl_t;

endpackage

`default_nettype wire

>>> hdl/toiq_cell.sv
// one slot of the sorted chain: holds one event and trades it with its neighbors
`default_nettype none

module toiq_cell #(
	parameter int TICK_BITS = 48,
	parameter int TAG_BITS  = 16
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  toiq_pkg::cell_ctrl_t     ctrl,
	input  wire  [TICK_BITS-1:0]     new_tick,
	input  wire  [TAG_BITS-1:0]      new_tag,
	input  wire                      new_auth,
	input  wire  [TICK_BITS-1:0]     now,
	input  wire                      left_valid,
	input  wire  [TICK_BITS-1:0]     left_tick,
	input  wire  [TAG_BITS-1:0]      left_tag,
	input  wire                      left_auth,
	input  wire                      left_gt,
	input  wire                      left_due,
	input  wire                      right_valid,
	input  wire  [TICK_BITS-1:0]     right_tick,
	input  wire  [TAG_BITS-1:0]      right_tag,
	input  wire                      right_auth,
	output logic                     valid,
	output logic [TICK_BITS-1:0]     tick,
	output logic [TAG_BITS-1:0]      tag,
	output logic                     auth,
	output logic                     gt,
	output logic                     due,
	output logic                     head_hit,
	output logic [TICK_BITS-1:0]     head_val
);
	import toiq_pkg::*;

	logic                 valid_q;
	logic [TICK_BITS-1:0] tick_q;
	logic [TAG_BITS-1:0]  tag_q;
	logic                 auth_q;
	logic                 take_left;
	logic                 take_new;

	// local compares: empty slots sort after everything and are never due
	always_comb begin
		gt       = !valid_q || (tick_q > new_tick);
		due      = valid_q && (tick_q <= now);
		head_hit = left_due && !due;
		head_val = valid_q ? tick_q : {TICK_BITS{1'b1}};
		take_left = ctrl.ins && gt && left_gt;
		take_new  = ctrl.ins && gt && !left_gt;
	end

	// occupancy bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.pop) begin
			valid_q <= right_valid;
		end else if (take_left) begin
			valid_q <= left_valid;
		end else if (take_new) begin
			valid_q <= 1'b1;
		end
	end

	// event payload: shift left on pop, shift right or load on insert
	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			tick_q <= right_tick;
			tag_q  <= right_tag;
			auth_q <= right_auth;
		end else if (take_left) begin
			tick_q <= left_tick;
			tag_q  <= left_tag;
			auth_q <= left_auth;
		end else if (take_new) begin
			tick_q <= new_tick;
			tag_q  <= new_tag;
			auth_q <= new_auth;
		end
	end

	assign valid = valid_q;
	assign tick  = tick_q;
	assign tag   = tag_q;
	assign auth  = auth_q;

endmodule

`default_nettype wire

>>> hdl/timestamp_ordered_issue_queue.sv
// top level of the timestamp-ordered issue queue: cell chain, sequencer, output register
//
// channel   dir  tdata (low bit up)                              tuser / tlast
// s_axis    in   event_tick, event_tag, event_authorized,         tuser: operation
//                now_tick, zero fill to bytes
// m_axis    out  out_tag, out_tick, out_authorized, head_tick,    tuser: out_valid, overflow
//                zero fill to bytes                               tlast: last
//
// an insert is placed by neighbor compares along the chain in the cycle it is accepted
// a release hands out its due events from the head cell, one per cycle while the result
// word can be taken, as the chain shifts toward the head; none due gives one empty word
// after reset every cell is empty; no clearing pass is needed
// m_tready low holds the result word and freezes the chain; s_tready stays low
// while a release is draining or a result cannot be taken
`default_nettype none

module timestamp_ordered_issue_queue #(
	parameter int DEPTH     = 32,
	parameter int TICK_BITS = 48,
	parameter int TAG_BITS  = 16,
	localparam int RAW_BITS = 2 * TICK_BITS + TAG_BITS + 1,
	localparam int BUS_BITS = ((RAW_BITS + 7) / 8) * 8
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	output logic                 s_tready,
	input  wire  [BUS_BITS-1:0]  s_tdata,  // event_tick, event_tag, event_authorized, now_tick
	input  wire                  s_tuser,  // operation
	output logic                 m_tvalid,
	input  wire                  m_tready,
	output logic [BUS_BITS-1:0]  m_tdata,  // out_tag, out_tick, out_authorized, head_tick
	output logic [1:0]           m_tuser,  // out_valid, overflow
	output logic                 m_tlast
);
	import toiq_pkg::*;

	typedef enum logic {ST_IDLE, ST_POP} state_t;

	state_t               state_q;
	logic [TICK_BITS-1:0] now_q;
	logic [TICK_BITS-1:0] head_q;
	logic                 m_tvalid_q;
	logic [TAG_BITS-1:0]  out_tag_q;
	logic [TICK_BITS-1:0] out_tick_q;
	logic                 out_auth_q;
	logic [TICK_BITS-1:0] out_head_q;
	logic                 out_valid_q;
	logic                 ovf_q;
	logic                 last_q;

	logic [TICK_BITS-1:0] in_tick;
	logic [TAG_BITS-1:0]  in_tag;
	logic                 in_auth;
	logic [TICK_BITS-1:0] in_now;
	logic                 accept;
	logic                 out_free;
	logic                 out_load;
	logic                 full;
	logic [TICK_BITS-1:0] now_sel;
	logic [TICK_BITS-1:0] head_ins;
	logic [TICK_BITS-1:0] head_rel;
	logic                 head_any;
	cell_ctrl_t           ctrl;
	logic [DEPTH-1:0]     vvec;

	// neighbor wiring: index 0 and DEPTH+1 are the chain ends, cell i sits at i+1
	logic                 cv [DEPTH+2];
	logic [TICK_BITS-1:0] ct [DEPTH+2];
	logic [TAG_BITS-1:0]  cg [DEPTH+2];
	logic                 ca [DEPTH+2];
	logic                 cgt [DEPTH+1];
	logic                 cdue [DEPTH+1];
	logic                 hhit [DEPTH];
	logic [TICK_BITS-1:0] hval [DEPTH];

	// input word fields
	assign in_tick = s_tdata[TICK_BITS-1:0];
	assign in_tag  = s_tdata[TICK_BITS +: TAG_BITS];
	assign in_auth = s_tdata[TICK_BITS+TAG_BITS];
	assign in_now  = s_tdata[TICK_BITS+TAG_BITS+1 +: TICK_BITS];

	// chain ends
	assign cv[0]       = 1'b0;
	assign ct[0]       = '0;
	assign cg[0]       = '0;
	assign ca[0]       = 1'b0;
	assign cgt[0]      = 1'b0;
	assign cdue[0]     = 1'b1;
	assign cv[DEPTH+1] = 1'b0;
	assign ct[DEPTH+1] = '0;
	assign cg[DEPTH+1] = '0;
	assign ca[DEPTH+1] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		toiq_cell #(
			.TICK_BITS (TICK_BITS),
			.TAG_BITS  (TAG_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.new_tick    (in_tick),
			.new_tag     (in_tag),
			.new_auth    (in_auth),
			.now         (now_sel),
			.left_valid  (cv[i]),
			.left_tick   (ct[i]),
			.left_tag    (cg[i]),
			.left_auth   (ca[i]),
			.left_gt     (cgt[i]),
			.left_due    (cdue[i]),
			.right_valid (cv[i+2]),
			.right_tick  (ct[i+2]),
			.right_tag   (cg[i+2]),
			.right_auth  (ca[i+2]),
			.valid       (cv[i+1]),
			.tick        (ct[i+1]),
			.tag         (cg[i+1]),
			.auth        (ca[i+1]),
			.gt          (cgt[i+1]),
			.due         (cdue[i+1]),
			.head_hit    (hhit[i]),
			.head_val    (hval[i])
		);
	end

	// handshake and chain commands
	always_comb begin
		out_free = !m_tvalid_q || m_tready;
		s_tready = (state_q == ST_IDLE) && out_free;
		accept   = s_tvalid && s_tready;
		out_load = (accept && (s_tuser == OP_INSERT)) || ((state_q == ST_POP) && out_free);
		full     = cv[DEPTH];
		ctrl.ins = accept && (s_tuser == OP_INSERT) && !full;
		ctrl.pop = (state_q == ST_POP) && out_free && cdue[1];
		now_sel  = (state_q == ST_IDLE) ? in_now : now_q;
		head_ins = (!full && cgt[1]) ? in_tick : (cv[1] ? ct[1] : {TICK_BITS{1'b1}});
	end

	// head after a release: the first cell that is not due, picked by a one-hot or
	always_comb begin
		head_rel = '0;
		head_any = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			head_rel = head_rel | (hhit[i] ? hval[i] : '0);
			head_any = head_any | hhit[i];
		end
		if (!head_any) begin
			head_rel = {TICK_BITS{1'b1}};
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			m_tvalid_q  <= 1'b0;
			now_q       <= '0;
			head_q      <= '0;
			out_valid_q <= 1'b0;
			out_tag_q   <= '0;
			out_tick_q  <= '0;
			out_auth_q  <= 1'b0;
			last_q      <= 1'b0;
			out_head_q  <= '0;
			ovf_q       <= 1'b0;
		end else begin
			// result word valid: set on a new word, cleared once taken
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (s_tuser == OP_INSERT)) begin
						out_valid_q <= 1'b0;
						out_tag_q   <= '0;
						out_tick_q  <= '0;
						out_auth_q  <= 1'b0;
						last_q      <= 1'b1;
						out_head_q  <= head_ins;
						ovf_q       <= full;
					end else if (accept) begin
						now_q   <= in_now;
						head_q  <= head_rel;
						state_q <= ST_POP;
					end
				end
				ST_POP: begin
					if (out_free) begin
						out_head_q <= head_q;
						ovf_q      <= 1'b0;
						if (cdue[1]) begin
							out_valid_q <= 1'b1;
							out_tag_q   <= cg[1];
							out_tick_q  <= ct[1];
							out_auth_q  <= ca[1];
							last_q      <= !cdue[2];
							if (!cdue[2]) begin
								state_q <= ST_IDLE;
							end
						end else begin
							out_valid_q <= 1'b0;
							out_tag_q   <= '0;
							out_tick_q  <= '0;
							out_auth_q  <= 1'b0;
							last_q      <= 1'b1;
							state_q     <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output word
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = BUS_BITS'({out_head_q, out_auth_q, out_tick_q, out_tag_q});
	assign m_tuser  = {ovf_q, out_valid_q};
	assign m_tlast  = last_q;

	// occupancy bits gathered for checks
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			vvec[i] = cv[i+1];
		end
	end

	// occupied cells always form a solid run from the head
	a_thermometer: assert property (@(posedge clk) disable iff (!arst_n)
		(vvec & (vvec + DEPTH'(1))) == '0)
		else $error("occupied cells are not contiguous from the head");

	// no new word is taken while a release drains
	a_no_accept_in_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP) |-> !s_tready)
		else $error("input ready during release");

	// a dropped insert never reports a released event
	a_ovf_no_event: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && ovf_q) |-> (!out_valid_q && last_q))
		else $error("overflow flagged on a released event");

	// an accepted insert into a non-full chain adds exactly one entry
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.ins |=> ($countones(vvec) == $past($countones(vvec)) + 1))
		else $error("insert did not add one entry");

	// a pop removes exactly one entry
	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |=> ($countones(vvec) + 1 == $past($countones(vvec))))
		else $error("pop did not remove one entry");

endmodule

`default_nettype wire

>>> tb/testbench.sv
// self-checking testbench for the timestamp-ordered issue queue
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import toiq_pkg::*;

	localparam int DEPTH       = 32;
	localparam int TICK_BITS   = 48;
	localparam int TAG_BITS    = 16;
	localparam int BUS_BITS    = 120;
	localparam int LOG_DEPTH   = 64;
	localparam int LIMIT_CYCLES = 3000000;
	localparam logic [TICK_BITS-1:0] TICK_ONES = '1;

	// one input word as the block sees it
	typedef struct packed {
		logic                 op;
		logic [TICK_BITS-1:0] tick;
		logic [TAG_BITS-1:0]  tag;
		logic                 auth;
		logic [TICK_BITS-1:0] now;
	} event_word_t;

	// one output word, fields as carried on m_tdata, m_tuser and m_tlast
	typedef struct packed {
		logic                 valid;
		logic [TAG_BITS-1:0]  tag;
		logic [TICK_BITS-1:0] tick;
		logic                 auth;
		logic                 last;
		logic [TICK_BITS-1:0] head;
		logic                 ovf;
	} issue_word_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [BUS_BITS-1:0] s_tdata = '0;
	logic                s_tuser = OP_INSERT;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [BUS_BITS-1:0] m_tdata;
	logic [1:0]          m_tuser;
	logic                m_tlast;

	// mirror of the sorted queue contents
	logic [TICK_BITS-1:0] held_tick [DEPTH];
	logic [TAG_BITS-1:0]  held_tag  [DEPTH];
	logic                 held_auth [DEPTH];
	int                   held_count = 0;

	// ring of expected words still outstanding
	issue_word_t issue_log [LOG_DEPTH];
	logic [5:0]  log_rd = '0;
	logic [5:0]  log_wr = '0;
	int          log_count = 0;
	int          mismatch_count = 0;
	int          cycle_count = 0;
	bit          quiet = 1'b0;

	timestamp_ordered_issue_queue #(
		.DEPTH(DEPTH),
		.TICK_BITS(TICK_BITS),
		.TAG_BITS(TAG_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// add one expected word at the tail of the ring
	function automatic void log_put(input issue_word_t r);
		issue_log[log_wr] = r;
		log_wr = log_wr + 6'd1;
		log_count++;
	endfunction

	// take the oldest expected word from the ring
	function automatic issue_word_t log_take();
		issue_word_t r;
		r = issue_log[log_rd];
		log_rd = log_rd + 6'd1;
		log_count--;
		return r;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet) return 0;
		if (r < 60) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [TICK_BITS-1:0] rand_tick();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[TICK_BITS-1:0];
	endfunction

	// apply one accepted word to the mirror and queue up the words it causes
	task automatic queue_operation(input event_word_t w);
		int                   pos;
		int                   n;
		int                   i;
		logic [TICK_BITS-1:0] head;
		issue_word_t          r;
		r = '0;
		r.last = 1'b1;
		if (w.op == OP_INSERT) begin
			if (held_count >= DEPTH) begin
				r.ovf = 1'b1;
			end else begin
				// stable placement: after every tick less than or equal
				pos = 0;
				while (pos < held_count && held_tick[pos] <= w.tick) pos++;
				for (i = held_count; i > pos; i--) begin
					held_tick[i] = held_tick[i-1];
					held_tag[i]  = held_tag[i-1];
					held_auth[i] = held_auth[i-1];
				end
				held_tick[pos] = w.tick;
				held_tag[pos]  = w.tag;
				held_auth[pos] = w.auth;
				held_count++;
			end
			r.head = (held_count == 0) ? TICK_ONES : held_tick[0];
			log_put(r);
		end else begin
			n = 0;
			while (n < held_count && held_tick[n] <= w.now) n++;
			if (n == 0) begin
				r.head = (held_count == 0) ? TICK_ONES : held_tick[0];
				log_put(r);
			end else begin
				head = (n < held_count) ? held_tick[n] : TICK_ONES;
				for (i = 0; i < n; i++) begin
					r.valid = 1'b1;
					r.tag   = held_tag[i];
					r.tick  = held_tick[i];
					r.auth  = held_auth[i];
					r.last  = (i == n - 1);
					r.head  = head;
					log_put(r);
				end
				for (i = n; i < held_count; i++) begin
					held_tick[i-n] = held_tick[i];
					held_tag[i-n]  = held_tag[i];
					held_auth[i-n] = held_auth[i];
				end
				held_count -= n;
			end
		end
	endtask

	// drive one word, hold it until the handshake, then update the mirror
	task automatic send_word(input event_word_t w);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= w.op;
		s_tdata  <= {7'b0, w.now, w.auth, w.tag, w.tick};
		do @(posedge clk); while (!s_tready);
		queue_operation(w);
	endtask

	// insert with an unused now_tick of random value
	task automatic send_insert(input logic [TICK_BITS-1:0] tick, input logic [TAG_BITS-1:0] tag,
			input logic auth);
		event_word_t w;
		w.op   = OP_INSERT;
		w.tick = tick;
		w.tag  = tag;
		w.auth = auth;
		w.now  = rand_tick();
		send_word(w);
	endtask

	// release with unused event fields of random value
	task automatic send_release(input logic [TICK_BITS-1:0] now);
		event_word_t w;
		w.op   = OP_RELEASE;
		w.tick = rand_tick();
		w.tag  = TAG_BITS'($urandom);
		w.auth = 1'($urandom);
		w.now  = now;
		send_word(w);
	endtask

	// stop sending until every outstanding word has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (log_count != 0);
	endtask

	// release on an empty queue reports all ones as head
	task automatic test_empty_release();
		send_release('0);
		send_release(TICK_ONES);
	endtask

	// lowest and highest ticks and tags, both authorized values
	task automatic test_field_extremes();
		send_insert(TICK_ONES, 16'hffff, 1'b1);
		send_insert('0, 16'h0000, 1'b0);
		send_insert(TICK_ONES, 16'h5a5a, 1'b0);
		send_release('0);
		send_release(TICK_ONES - TICK_BITS'(1));
		send_release(TICK_ONES);
	endtask

	// equal ticks leave in arrival order, unauthorized ones pop as usual
	task automatic test_equal_ticks();
		send_insert(48'd100, 16'd1, 1'b1);
		send_insert(48'd50,  16'd2, 1'b0);
		send_insert(48'd100, 16'd3, 1'b0);
		send_insert(48'd100, 16'd4, 1'b1);
		send_insert(48'd75,  16'd5, 1'b1);
		send_insert(48'd150, 16'd6, 1'b0);
		send_release(48'd99);
		send_release(48'd100);
		send_release(48'd149);
		send_release(48'd150);
	endtask

	// fill to the top, push past it, then flush everything in one release
	task automatic test_fill_and_flush();
		logic [TICK_BITS-1:0] base;
		int                   k;
		base = rand_tick() >> $urandom_range(1, 47);
		k = 0;
		while (held_count < DEPTH && k < 200) begin
			send_insert(base + TICK_BITS'($urandom_range(0, 20)), TAG_BITS'($urandom),
				1'($urandom));
			k++;
		end
		repeat (3) send_insert(base + TICK_BITS'($urandom_range(0, 20)), TAG_BITS'($urandom),
			1'($urandom));
		wait_drained();
		send_release(TICK_ONES);
	endtask

	// mixed traffic around a moving tick, with some full-range noise
	task automatic test_mixed_traffic(input int count);
		logic [TICK_BITS-1:0] base;
		int                   r;
		int                   k;
		base = rand_tick() >> $urandom_range(1, 47);
		for (k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				send_insert(base + TICK_BITS'($urandom_range(0, 40)), TAG_BITS'($urandom),
					1'($urandom));
			end else if (r < 57) begin
				send_insert(rand_tick(), TAG_BITS'($urandom), 1'($urandom));
			end else if (r < 92) begin
				send_release(base + TICK_BITS'($urandom_range(0, 20)));
				base = base + TICK_BITS'($urandom_range(0, 12));
			end else begin
				send_release(rand_tick());
			end
		end
	endtask

	// full rate on both sides
	task automatic test_back_to_back(input int count);
		wait_drained();
		quiet = 1'b1;
		test_mixed_traffic(count);
		quiet = 1'b0;
	endtask

	// receiver: ready in runs, with stalls of random length
	initial begin
		int n;
		forever begin
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			n = idle_len();
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	end

	// compare each accepted word with the oldest outstanding one
	always @(posedge clk) begin
		issue_word_t got;
		issue_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.tag   = m_tdata[15:0];
			got.tick  = m_tdata[63:16];
			got.auth  = m_tdata[64];
			got.head  = m_tdata[112:65];
			got.valid = m_tuser[0];
			got.ovf   = m_tuser[1];
			got.last  = m_tlast;
			if (log_count == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: unexpected word valid=%b tag=%h tick=%h auth=%b last=%b head=%h ovf=%b",
						$realtime, got.valid, got.tag, got.tick, got.auth, got.last,
						got.head, got.ovf);
			end else begin
				want = log_take();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("%0t: mismatch", $realtime);
						$display("  exp valid=%b tag=%h tick=%h auth=%b last=%b head=%h ovf=%b",
							want.valid, want.tag, want.tick, want.auth, want.last,
							want.head, want.ovf);
						$display("  got valid=%b tag=%h tick=%h auth=%b last=%b head=%h ovf=%b",
							got.valid, got.tag, got.tick, got.auth, got.last,
							got.head, got.ovf);
					end
				end
			end
		end
	end

	// run limit
	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// reset, then the tests in turn
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_release();
		test_field_extremes();
		test_equal_ticks();
		test_mixed_traffic(120);
		test_fill_and_flush();
		test_back_to_back(50);
		test_mixed_traffic(50);
		wait_drained();
		// every expected word is back; wait on so that any unexpected trailing words show up
		repeat (60) @(posedge clk);
		if (mismatch_count == 0 && log_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

>>> timestamp_ordered_issue_queue.f
hdl/toiq_pkg.sv
hdl/toiq_cell.sv
hdl/timestamp_ordered_issue_queue.sv
tb/testbench.sv
